// ===== src/fraction_add_reduce_defines.svh =====
// Assertion macros shared by the fraction adder modules.
// No dependencies.
`ifndef FRACTION_ADD_REDUCE_DEFINES_SVH
`define FRACTION_ADD_REDUCE_DEFINES_SVH
// Implication checked at every clock edge outside reset.
`define FAR_ASSERT_IMP(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define FAR_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);
`endif

// ===== src/far_pkg.sv =====
// Types and constants for the fraction adder.
// No dependencies.
`timescale 1ns / 1ps
package far_pkg;
  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL1, ST_MUL2, ST_MUL3, ST_GCD, ST_DIVN, ST_DIVD, ST_DONE
  } far_state_t;
endpackage

// ===== src/far_if.sv =====
// Valid/ready channel interface with a generic payload.
// Depends on nothing.
`timescale 1ns / 1ps
interface far_if #(parameter int W = 8) (input logic clk);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/far_div.sv =====
// Restoring bit-serial divider, one quotient bit per cycle, quotient and remainder.
// Depends on far_pkg and the assertion macros.
`timescale 1ns / 1ps
`include "fraction_add_reduce_defines.svh"
module far_div #(
  parameter int W = 33
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient,
  output logic [W-1:0] remainder
);
  import far_pkg::*;
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  quo;
  logic [W-1:0]  rem;
  logic [W-1:0]  dvs;
  logic [CW-1:0] count;
  logic          busy;
  logic [W:0]    trial;

  assign trial = {rem, quo[W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CW'(W);
        quo   <= dividend;
        rem   <= '0;
        dvs   <= divisor;
      end else if (busy) begin
        if (trial >= {1'b0, dvs}) begin
          rem <= W'(trial - {1'b0, dvs});
          quo <= {quo[W-2:0], 1'b1};
        end else begin
          rem <= trial[W-1:0];
          quo <= {quo[W-2:0], 1'b0};
        end
        count <= count - 1'b1;
        if (count == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

  `FAR_ASSERT_NEXT(a_div_done, busy && count == CW'(1) && !start, done, "divider missed done")
  `FAR_ASSERT_IMP(a_div_excl, done, !busy, "divider done while busy")
  `FAR_ASSERT_IMP(a_div_cnt, busy, count != '0, "divider count underflow")
endmodule

// ===== src/fraction_add_reduce.sv =====
// Top level of the fraction adder with Euclidean reduction.
// Depends on far_pkg, far_if, far_div and the assertion macros.
`timescale 1ns / 1ps
`include "fraction_add_reduce_defines.svh"
// From acceptance the block forms the two cross products and the denominator product,
// runs Euclid's algorithm with one divider pass per step, then divides the numerator
// and the denominator by the GCD; each divider pass yields all 33 quotient bits.
// A zero denominator skips the arithmetic and a zero sum skips the divisions.
// One request at a time: the next is taken in the cycle the result appears, unless the
// output register still holds an untaken sum. Synchronous active-high reset to idle.
module fraction_add_reduce #(
  parameter int OPERAND_WIDTH = 16
) (
  input  logic clk,
  input  logic rst,
  far_if.sink   in,
  far_if.source out
);
  import far_pkg::*;
  localparam int OW = OPERAND_WIDTH;
  localparam int NW = 2 * OW + 1;
  localparam int DW = 2 * OW;

  // Input payload: sign_a, numerator_a, denominator_a, sign_b, numerator_b,
  // denominator_b, first field in the top bits.
  logic          sa, sb;
  logic [OW-1:0] na, da, nb, db;
  assign {sa, na, da, sb, nb, db} = in.data;

  far_state_t state, state_next;
  logic [OW-1:0] ra_n, ra_d, rb_n, rb_d;
  logic          rsa, rsb;
  logic [DW-1:0] p1, p2;
  logic [NW-1:0] ga, gb, num, den;
  logic          sign;
  logic          res_sign, res_bad;
  logic [NW-1:0] res_num;
  logic [DW-1:0] res_den;
  // The output register holds a finished sum while the block works on the next one.
  logic          out_sign, out_bad;
  logic [NW-1:0] out_num;
  logic [DW-1:0] out_den;
  logic          ovalid;

  // One 16x16 multiplier is shared by the states ST_MUL1, ST_MUL2 and ST_MUL3.
  logic [OW-1:0] mx, my;
  logic [DW-1:0] prod;
  assign prod = DW'(mx) * DW'(my);
  always_comb begin
    mx = ra_n; my = rb_d;
    case (state)
      ST_MUL2: begin mx = rb_n; my = ra_d; end
      ST_MUL3: begin mx = ra_d; my = rb_d; end
      default: begin mx = ra_n; my = rb_d; end
    endcase
  end

  // Shared divider: Euclid remainders, then the two final divisions.
  logic          dstart, ddone;
  logic [NW-1:0] dvd, dvs, quo, rem;
  far_div #(.W(NW)) u_div (
    .clk, .rst, .start(dstart), .dividend(dvd), .divisor(dvs),
    .done(ddone), .quotient(quo), .remainder(rem)
  );
  logic launched;

  always_comb begin
    state_next = state;
    dstart     = 1'b0;
    dvd        = ga;
    dvs        = gb;
    case (state)
      ST_IDLE: begin
        // A zero denominator skips the arithmetic and goes straight to the result.
        if (in.valid) state_next = (da == '0 || db == '0) ? ST_DONE : ST_MUL1;
      end
      ST_MUL1: state_next = ST_MUL2;
      ST_MUL2: state_next = ST_MUL3;
      ST_MUL3: state_next = ST_GCD;
      ST_GCD: begin
        if (!launched) begin
          if (num == '0) state_next = ST_DONE;
          else if (gb == '0) state_next = ST_DIVN;
          else dstart = 1'b1;
        end
      end
      ST_DIVN: begin
        dvd = num; dvs = ga;
        if (!launched) dstart = 1'b1;
        else if (ddone) state_next = ST_DIVD;
      end
      ST_DIVD: begin
        dvd = den; dvs = ga;
        if (!launched) dstart = 1'b1;
        else if (ddone) state_next = ST_DONE;
      end
      ST_DONE: if (!ovalid || out.ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  assign in.ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      ovalid   <= 1'b0;
      launched <= 1'b0;
    end else begin
      if (state == ST_DONE && (!ovalid || out.ready)) begin
        ovalid   <= 1'b1;
        out_sign <= res_sign;
        out_num  <= res_num;
        out_den  <= res_den;
        out_bad  <= res_bad;
      end else if (ovalid && out.ready) begin
        ovalid <= 1'b0;
      end
      if (state != state_next) launched <= 1'b0;
      else if (dstart) launched <= 1'b1;
      else if (state == ST_GCD && ddone) launched <= 1'b0;
      state <= state_next;
      case (state)
        ST_IDLE: if (in.valid) begin
          rsa <= sa; rsb <= sb; ra_n <= na; ra_d <= da; rb_n <= nb; rb_d <= db;
          if (da == '0 || db == '0) begin
            // Zero denominator: flag and zero the other fields.
            res_bad <= 1'b1; res_sign <= 1'b0; res_num <= '0; res_den <= '0;
          end
        end
        ST_MUL1: p1 <= prod;
        ST_MUL2: p2 <= prod;
        ST_MUL3: begin
          den <= NW'(prod);
          if (rsa == rsb) begin
            num <= NW'(p1) + NW'(p2); sign <= rsa;
          end else if (p1 >= p2) begin
            num <= NW'(p1 - p2); sign <= rsa;
          end else begin
            num <= NW'(p2 - p1); sign <= rsb;
          end
        end
        ST_GCD: begin
          if (!launched && num == '0) begin
            // Zero sum reduces to +0/1.
            res_bad <= 1'b0; res_sign <= 1'b0; res_num <= '0; res_den <= DW'(1);
          end else if (launched && ddone) begin
            ga <= gb; gb <= rem;
          end
        end
        ST_DIVN: if (launched && ddone) res_num <= quo;
        ST_DIVD: if (launched && ddone) begin
          res_den <= DW'(quo); res_sign <= sign; res_bad <= 1'b0;
        end
        default: ;
      endcase
      if (state == ST_MUL3) begin
        ga <= (rsa == rsb) ? NW'(p1) + NW'(p2)
            : (p1 >= p2) ? NW'(p1 - p2) : NW'(p2 - p1);
        gb <= NW'(prod);
      end
    end
  end

  assign out.valid = ovalid;
  assign out.data  = {out_sign, out_num, out_den, out_bad};

  `FAR_ASSERT_IMP(a_rdy_idle, in.ready, !ovalid || state == ST_IDLE, "ready outside idle")
  `FAR_ASSERT_IMP(a_bad_zero, ovalid && out_bad, out_num == '0 && out_den == '0, "bad fields")
  `FAR_ASSERT_IMP(a_den_nz, ovalid && !out_bad, out_den != '0, "zero denominator out")
  `FAR_ASSERT_NEXT(a_hold, ovalid && !out.ready, ovalid, "result dropped")
endmodule
